FILE: rtl/ppps_pkg.sv
// ---------------------------------------------------------------------------
// Pump pressure profile sequencer package
// Shared constants, register indexes and field widths for the sequencer.
// ---------------------------------------------------------------------------
package ppps_pkg;

   localparam int DUTY_W  = 9;
   localparam int PROG_W  = 10;
   localparam int STEP_W  = 5;
   localparam int ALARM_W = 4;
   localparam int SHOT_W  = 16;
   localparam int IDLE_W  = 12;
   localparam int CSR_W   = 10;
   localparam int CSR_A_W = 3;

   // fixed profile constants
   localparam logic [DUTY_W-1:0]  FULL_DUTY      = 9'd256;
   localparam logic [DUTY_W-1:0]  DUTY_MAX       = 9'd511;
   localparam logic [PROG_W-1:0]  BOOST_LIMIT    = 10'd200;
   localparam logic [PROG_W-1:0]  PUMP_OFF_AT    = 10'd600;
   localparam logic [PROG_W-1:0]  PROG_MAX       = 10'd1023;
   localparam logic [PROG_W:0]    LATE_HOLD_BASE = 11'd300;
   localparam logic [PROG_W:0]    AUTO_END_BASE  = 11'd250;
   localparam logic [PROG_W:0]    WARN_GAP       = 11'd5;
   localparam logic [PROG_W-1:0]  REWIND_SHORT   = 10'd25;
   localparam logic [PROG_W-1:0]  REWIND_LONG    = 10'd250;
   localparam logic [ALARM_W-1:0] ALARM_SOLID    = 4'd10;
   localparam logic [IDLE_W-1:0]  IDLE_CLEAR     = 12'd4000;
   localparam logic [IDLE_W-1:0]  IDLE_MAX       = 12'd4095;
   localparam logic [SHOT_W-1:0]  SHOT_MAX       = 16'hFFFF;

   // ramp and decline pacing: manual shot, then auto shot
   localparam logic [STEP_W-1:0] MAN_UP_WAIT    = 5'd4;
   localparam logic [STEP_W-1:0] MAN_UP_STEP    = 5'd12;
   localparam logic [STEP_W-1:0] MAN_DOWN_WAIT  = 5'd10;
   localparam logic [1:0]        MAN_DOWN_STEP  = 2'd1;
   localparam logic [STEP_W-1:0] AUTO_UP_WAIT   = 5'd5;
   localparam logic [STEP_W-1:0] AUTO_UP_STEP   = 5'd16;
   localparam logic [STEP_W-1:0] AUTO_DOWN_WAIT = 5'd15;
   localparam logic [1:0]        AUTO_DOWN_STEP = 2'd2;

   // register reset values
   localparam logic [8:0] RST_PREINFUSE_DUTY = 9'd120;
   localparam logic [7:0] RST_PREINFUSE_END  = 8'd30;
   localparam logic [8:0] RST_SOAK_END       = 9'd60;
   localparam logic [8:0] RST_RAMP_END       = 9'd90;
   localparam logic [9:0] RST_HOLD_END       = 10'd801;
   localparam logic [8:0] RST_MIN_DUTY       = 9'd26;
   localparam logic [9:0] RST_WARNING_START  = 10'd851;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_PREINFUSE_DUTY = 3'd0,
      CSR_PREINFUSE_END  = 3'd1,
      CSR_SOAK_END       = 3'd2,
      CSR_RAMP_END       = 3'd3,
      CSR_HOLD_END       = 3'd4,
      CSR_MIN_DUTY       = 3'd5,
      CSR_WARNING_START  = 3'd6,
      CSR_UNUSED         = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic              auto_shot;
      logic [SHOT_W-1:0] shot_seconds_tenths;
      logic              boiler_boost;
      logic              alarm;
      logic              brew_valve;
      logic [DUTY_W-1:0] pump_duty;
   } rsp_fields_type;

endpackage

FILE: rtl/pump_pressure_profile_sequencer.sv
// ---------------------------------------------------------------------------
// Pump pressure profile sequencer
// Espresso shot sequencer: preinfusion, soak, ramp, decline, alarm, auto shot.
// ---------------------------------------------------------------------------
// A request's response is registered at accept and shown in the cycle after it.
// Throughput: one request per clock while req_tready is high; state update is a single registered pass.
// req_tready drops only while a response is held and rsp_tready is low.
// Reset (synchronous, active high): all sequence state cleared, registers back
// to their defaults, response register empty.
// ---------------------------------------------------------------------------
module pump_pressure_profile_sequencer
   import ppps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [0] power_on, [1] brew_switch, [2] tick
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // [8:0] pump_duty, [9] brew_valve, [10] alarm,
                                           // [11] boiler_boost, [27:12] shot_seconds_tenths,
                                           // [28] auto_shot
   // register write port
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   // configuration registers
   logic [8:0] preinfuse_duty_ff;
   logic [7:0] preinfuse_end_ff;
   logic [8:0] soak_end_ff;
   logic [8:0] ramp_end_ff;
   logic [9:0] hold_end_ff;
   logic [8:0] min_duty_ff;
   logic [9:0] warning_start_ff;

   // sequence state
   logic [PROG_W-1:0]  progress_ff,     progress_in;
   logic [DUTY_W-1:0]  duty_ff,         duty_in;
   logic [STEP_W-1:0]  step_count_ff,   step_count_in;
   logic [ALARM_W-1:0] alarm_cycles_ff, alarm_cycles_in;
   logic               auto_flag_ff,    auto_flag_in;
   logic [SHOT_W-1:0]  shot_time_ff,    shot_time_in;
   logic [IDLE_W-1:0]  idle_count_ff,   idle_count_in;
   logic               buzzer_ff,       buzzer_in;
   logic               valve_ff,        valve_in;
   logic               boost_in;

   // response register
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   rsp_fields_type     rsp_fields_ff, rsp_fields_in;

   logic req_accept;
   logic pwr, brew, tick;

   assign pwr  = req_tdata[0];
   assign brew = req_tdata[1];
   assign tick = req_tdata[2];

   // a held response only blocks when the far side is stalling
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // -----------------------------------------------------------------------
   // Register writes
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         preinfuse_duty_ff <= RST_PREINFUSE_DUTY;
         preinfuse_end_ff  <= RST_PREINFUSE_END;
         soak_end_ff       <= RST_SOAK_END;
         ramp_end_ff       <= RST_RAMP_END;
         hold_end_ff       <= RST_HOLD_END;
         min_duty_ff       <= RST_MIN_DUTY;
         warning_start_ff  <= RST_WARNING_START;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_PREINFUSE_DUTY: preinfuse_duty_ff <= csr_wdata[8:0];
            CSR_PREINFUSE_END:  preinfuse_end_ff  <= csr_wdata[7:0];
            CSR_SOAK_END:       soak_end_ff       <= csr_wdata[8:0];
            CSR_RAMP_END:       ramp_end_ff       <= csr_wdata[8:0];
            CSR_HOLD_END:       hold_end_ff       <= csr_wdata[9:0];
            CSR_MIN_DUTY:       min_duty_ff       <= csr_wdata[8:0];
            CSR_WARNING_START:  warning_start_ff  <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // One control pass. Comparisons use the progress held at entry to the
   // pass, apart from the alarm rewind and the tick, which see it as updated.
   // -----------------------------------------------------------------------
   always_comb begin
      logic [STEP_W-1:0] up_wait;
      logic [STEP_W-1:0] up_step;
      logic [STEP_W-1:0] down_wait;
      logic [1:0]        down_step;
      logic [DUTY_W:0]   duty_sum;
      logic [PROG_W-1:0] p;
      logic [PROG_W-1:0] pe;
      logic [PROG_W-1:0] se;
      logic [PROG_W-1:0] re;
      logic              run;

      p         = progress_ff;
      pe        = {2'b00, preinfuse_end_ff};
      se        = {1'b0, soak_end_ff};
      re        = {1'b0, ramp_end_ff};
      up_wait   = brew ? MAN_UP_WAIT    : AUTO_UP_WAIT;
      up_step   = brew ? MAN_UP_STEP    : AUTO_UP_STEP;
      down_wait = brew ? MAN_DOWN_WAIT  : AUTO_DOWN_WAIT;
      down_step = brew ? MAN_DOWN_STEP  : AUTO_DOWN_STEP;
      duty_sum  = '0;
      run       = pwr && (brew || auto_flag_ff);

      progress_in     = progress_ff;
      duty_in         = duty_ff;
      step_count_in   = step_count_ff;
      alarm_cycles_in = alarm_cycles_ff;
      auto_flag_in    = auto_flag_ff;
      shot_time_in    = shot_time_ff;
      idle_count_in   = idle_count_ff;
      buzzer_in       = buzzer_ff;
      valve_in        = valve_ff;
      boost_in        = 1'b0;

      // shared profile: preinfusion, soak, ramp, decline
      if (run) begin
         boost_in = (p < BOOST_LIMIT);
         if (p <= pe) begin
            valve_in = 1'b1;
            duty_in  = preinfuse_duty_ff;
            if (brew) auto_flag_in = 1'b1;
         end
         if (p > pe && p <= se) begin
            duty_in = '0;
            if (brew) auto_flag_in = 1'b0;
         end
         if (p > se && p <= re && duty_in <= FULL_DUTY) begin
            step_count_in = step_count_in + 1'b1;
            if (step_count_in > up_wait) begin
               if (duty_in < FULL_DUTY) begin
                  duty_sum = {1'b0, duty_in} + {{(DUTY_W+1-STEP_W){1'b0}}, up_step};
                  duty_in  = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX
                                                           : duty_sum[DUTY_W-1:0];
               end
               step_count_in = '0;
            end
         end
         if (p > re && p <= hold_end_ff && duty_in >= min_duty_ff) begin
            step_count_in = step_count_in + 1'b1;
            if (step_count_in > down_wait) begin
               duty_in = (duty_in > {{(DUTY_W-2){1'b0}}, down_step})
                         ? duty_in - {{(DUTY_W-2){1'b0}}, down_step} : '0;
               step_count_in = '0;
            end
         end
      end

      priority if (!pwr) begin
         duty_in      = '0;
         valve_in     = 1'b0;
         buzzer_in    = 1'b0;
         shot_time_in = '0;
         auto_flag_in = 1'b0;
      end else if (brew) begin
         idle_count_in = '0;
         if ({1'b0, p} > LATE_HOLD_BASE + {1'b0, pe} + {1'b0, se}) duty_in = min_duty_ff;
         if (p > PUMP_OFF_AT) duty_in = '0;
         if (p >= warning_start_ff) buzzer_in = 1'b1;
         // pulse: back off a little and count the pulse
         if ({1'b0, p} >= {1'b0, warning_start_ff} + WARN_GAP) begin
            buzzer_in       = 1'b0;
            progress_in     = (warning_start_ff > REWIND_SHORT)
                              ? warning_start_ff - REWIND_SHORT : '0;
            alarm_cycles_in = alarm_cycles_in + 1'b1;
         end
         // solid alarm after enough pulses
         if (alarm_cycles_in >= ALARM_SOLID) begin
            buzzer_in       = 1'b1;
            progress_in     = (warning_start_ff > REWIND_LONG)
                              ? warning_start_ff - REWIND_LONG : '0;
            alarm_cycles_in = ALARM_SOLID;
         end
         if (tick) begin
            if (progress_in < PROG_MAX) progress_in = progress_in + 1'b1;
            if (progress_in > se && shot_time_in < SHOT_MAX)
               shot_time_in = shot_time_in + 1'b1;
         end
      end else if (auto_flag_ff) begin
         if ({1'b0, p} + {1'b0, pe} > AUTO_END_BASE + {1'b0, se}) begin
            duty_in      = '0;
            auto_flag_in = 1'b0;
         end
         if (tick && p < PROG_MAX) progress_in = p + 1'b1;
      end else begin
         valve_in        = 1'b0;
         buzzer_in       = 1'b0;
         alarm_cycles_in = '0;
         progress_in     = '0;
         duty_in         = '0;
         if (idle_count_in < IDLE_MAX) idle_count_in = idle_count_in + 1'b1;
         if (idle_count_in >= IDLE_CLEAR) shot_time_in = '0;
      end

      rsp_fields_in.pump_duty           = duty_in;
      rsp_fields_in.brew_valve          = valve_in;
      rsp_fields_in.alarm               = buzzer_in;
      rsp_fields_in.boiler_boost        = boost_in;
      rsp_fields_in.shot_seconds_tenths = shot_time_in;
      rsp_fields_in.auto_shot           = auto_flag_in;
   end

   // -----------------------------------------------------------------------
   // State and response registers
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff     <= '0;
         duty_ff         <= '0;
         step_count_ff   <= '0;
         alarm_cycles_ff <= '0;
         auto_flag_ff    <= 1'b0;
         shot_time_ff    <= '0;
         idle_count_ff   <= '0;
         buzzer_ff       <= 1'b0;
         valve_ff        <= 1'b0;
      end else if (req_accept) begin
         progress_ff     <= progress_in;
         duty_ff         <= duty_in;
         step_count_ff   <= step_count_in;
         alarm_cycles_ff <= alarm_cycles_in;
         auto_flag_ff    <= auto_flag_in;
         shot_time_ff    <= shot_time_in;
         idle_count_ff   <= idle_count_in;
         buzzer_ff       <= buzzer_in;
         valve_ff        <= valve_in;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (req_accept)      rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else       rsp_tvalid_ff <= rsp_tvalid_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_fields_ff <= rsp_fields_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_fields_ff};

   // -----------------------------------------------------------------------
   // Checks
   // -----------------------------------------------------------------------
   // power off leaves pump, valve and auto shot cleared in the response
   a_power_off_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && !pwr |=> rsp_tvalid && rsp_fields_ff.pump_duty == '0
                             && !rsp_fields_ff.brew_valve && !rsp_fields_ff.auto_shot)
      else $error("power off did not clear outputs");

   // alarm pulse count never passes the solid level
   a_alarm_bound: assert property (@(posedge clock) disable iff (reset)
      alarm_cycles_ff <= ALARM_SOLID)
      else $error("alarm cycle count out of range");

   // step counter is always cleared once it passes the longest wait
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_count_ff <= AUTO_DOWN_WAIT)
      else $error("step counter out of range");

   // an empty response register never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid_ff |-> req_tready)
      else $error("request stalled with empty response register");

endmodule

FILE: bench/ppps_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pump pressure profile sequencer checker
// Watches the request, response and register ports, predicts every response
// from its own copy of the shot state and compares field by field, in order.
// ---------------------------------------------------------------------------
module ppps_checker
   import ppps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [7:0]         req_tdata,   // [0] power_on, [1] brew_switch, [2] tick
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [31:0]        rsp_tdata,   // [8:0] pump_duty, [9] brew_valve, [10] alarm,
                                           // [11] boiler_boost, [27:12] shot_seconds_tenths,
                                           // [28] auto_shot
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int unsigned        mismatch_count,
   output int unsigned        pending_count
);

   rsp_fields_type expected_q[$];

   // register copies
   logic [8:0]  cfg_pi_duty;
   logic [7:0]  cfg_pi_stop;
   logic [8:0]  cfg_soak_stop;
   logic [8:0]  cfg_ramp_stop;
   logic [9:0]  cfg_decl_stop;
   logic [8:0]  cfg_floor_duty;
   logic [9:0]  cfg_warn_at;

   // shot state
   logic [PROG_W-1:0]  shot_prog;
   logic [DUTY_W-1:0]  pump_lvl;
   logic [STEP_W-1:0]  pace_cnt;
   logic [ALARM_W-1:0] beep_rounds;
   logic               auto_on;
   logic [SHOT_W-1:0]  brew_clock;
   logic [IDLE_W-1:0]  rest_cnt;
   logic               beeper;
   logic               valve_open;

   function automatic int unsigned floor_sub(int unsigned a, int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   function automatic void restore_defaults();
      cfg_pi_duty    = RST_PREINFUSE_DUTY;
      cfg_pi_stop    = RST_PREINFUSE_END;
      cfg_soak_stop  = RST_SOAK_END;
      cfg_ramp_stop  = RST_RAMP_END;
      cfg_decl_stop  = RST_HOLD_END;
      cfg_floor_duty = RST_MIN_DUTY;
      cfg_warn_at    = RST_WARNING_START;
      shot_prog      = '0;
      pump_lvl       = '0;
      pace_cnt       = '0;
      beep_rounds    = '0;
      auto_on        = 1'b0;
      brew_clock     = '0;
      rest_cnt       = '0;
      beeper         = 1'b0;
      valve_open     = 1'b0;
   endfunction

   function automatic void apply_csr(logic [CSR_A_W-1:0] idx, logic [CSR_W-1:0] val);
      case (csr_index_type'(idx))
         CSR_PREINFUSE_DUTY: cfg_pi_duty    = val[8:0];
         CSR_PREINFUSE_END:  cfg_pi_stop    = val[7:0];
         CSR_SOAK_END:       cfg_soak_stop  = val[8:0];
         CSR_RAMP_END:       cfg_ramp_stop  = val[8:0];
         CSR_HOLD_END:       cfg_decl_stop  = val[9:0];
         CSR_MIN_DUTY:       cfg_floor_duty = val[8:0];
         CSR_WARNING_START:  cfg_warn_at    = val[9:0];
         default: ;
      endcase
   endfunction

   // preinfusion, soak, ramp and decline; pacing differs for manual and auto shots
   function automatic void advance_profile(bit manual);
      int unsigned up_wait, up_step, down_wait, down_step, lvl;
      up_wait   = manual ? MAN_UP_WAIT   : AUTO_UP_WAIT;
      up_step   = manual ? MAN_UP_STEP   : AUTO_UP_STEP;
      down_wait = manual ? MAN_DOWN_WAIT : AUTO_DOWN_WAIT;
      down_step = manual ? MAN_DOWN_STEP : AUTO_DOWN_STEP;
      if (shot_prog <= cfg_pi_stop) begin
         valve_open = 1'b1;
         pump_lvl   = cfg_pi_duty;
         if (manual) auto_on = 1'b1;
      end
      if (shot_prog > cfg_pi_stop && shot_prog <= cfg_soak_stop) begin
         pump_lvl = '0;
         if (manual) auto_on = 1'b0;
      end
      if (shot_prog > cfg_soak_stop && shot_prog <= cfg_ramp_stop && pump_lvl <= FULL_DUTY) begin
         pace_cnt = pace_cnt + 1'b1;
         if (pace_cnt > up_wait) begin
            if (pump_lvl < FULL_DUTY) begin
               lvl      = pump_lvl + up_step;
               pump_lvl = (lvl > DUTY_MAX) ? DUTY_MAX : lvl[DUTY_W-1:0];
            end
            pace_cnt = '0;
         end
      end
      if (shot_prog > cfg_ramp_stop && shot_prog <= cfg_decl_stop
          && pump_lvl >= cfg_floor_duty) begin
         pace_cnt = pace_cnt + 1'b1;
         if (pace_cnt > down_wait) begin
            pump_lvl = DUTY_W'(floor_sub(pump_lvl, down_step));
            pace_cnt = '0;
         end
      end
   endfunction

   function automatic rsp_fields_type next_pass(bit pwr, bit brew, bit tick);
      rsp_fields_type r;
      bit boost;
      boost = 1'b0;
      if (!pwr) begin
         pump_lvl   = '0;
         valve_open = 1'b0;
         beeper     = 1'b0;
         brew_clock = '0;
         auto_on    = 1'b0;
      end else if (brew) begin
         boost    = (shot_prog < BOOST_LIMIT);
         rest_cnt = '0;
         advance_profile(1'b1);
         if (int'(shot_prog) > int'(LATE_HOLD_BASE) + int'(cfg_pi_stop) + int'(cfg_soak_stop))
            pump_lvl = cfg_floor_duty;
         if (shot_prog > PUMP_OFF_AT) pump_lvl = '0;
         if (shot_prog >= cfg_warn_at) beeper = 1'b1;
         if (int'(shot_prog) >= int'(cfg_warn_at) + int'(WARN_GAP)) begin
            beeper      = 1'b0;
            shot_prog   = PROG_W'(floor_sub(cfg_warn_at, REWIND_SHORT));
            beep_rounds = beep_rounds + 1'b1;
         end
         if (beep_rounds >= ALARM_SOLID) begin
            beeper      = 1'b1;
            shot_prog   = PROG_W'(floor_sub(cfg_warn_at, REWIND_LONG));
            beep_rounds = ALARM_SOLID;
         end
         if (tick) begin
            if (shot_prog < PROG_MAX) shot_prog = shot_prog + 1'b1;
            if (shot_prog > cfg_soak_stop && brew_clock < SHOT_MAX) brew_clock = brew_clock + 1'b1;
         end
      end else if (auto_on) begin
         boost = (shot_prog < BOOST_LIMIT);
         advance_profile(1'b0);
         if (int'(shot_prog) + int'(cfg_pi_stop) > int'(AUTO_END_BASE) + int'(cfg_soak_stop)) begin
            pump_lvl = '0;
            auto_on  = 1'b0;
         end
         if (tick && shot_prog < PROG_MAX) shot_prog = shot_prog + 1'b1;
      end else begin
         valve_open  = 1'b0;
         beeper      = 1'b0;
         beep_rounds = '0;
         shot_prog   = '0;
         pump_lvl    = '0;
         if (rest_cnt < IDLE_MAX) rest_cnt = rest_cnt + 1'b1;
         if (rest_cnt >= IDLE_CLEAR) brew_clock = '0;
      end
      r.pump_duty           = pump_lvl;
      r.brew_valve          = valve_open;
      r.alarm               = beeper;
      r.boiler_boost        = boost;
      r.shot_seconds_tenths = brew_clock;
      r.auto_shot           = auto_on;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_fields_type want, got;
      bit bad;
      if (reset) begin
         restore_defaults();
         expected_q.delete();
      end else begin
         // responses first: one accepted at this edge belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_fields_type'(rsp_tdata[28:0]);
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response %h with no request outstanding", $realtime, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               bad  = (got.pump_duty !== want.pump_duty)
                   || (got.brew_valve !== want.brew_valve)
                   || (got.alarm !== want.alarm)
                   || (got.boiler_boost !== want.boiler_boost)
                   || (got.shot_seconds_tenths !== want.shot_seconds_tenths)
                   || (got.auto_shot !== want.auto_shot)
                   || (rsp_tdata[31:29] !== 3'b000);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("%0t: response mismatch (exp/got) duty %0d/%0d valve %b/%b ",
                            $realtime, want.pump_duty, got.pump_duty,
                            want.brew_valve, got.brew_valve);
                     $display("alarm %b/%b boost %b/%b shot %0d/%0d auto %b/%b pad %b",
                              want.alarm, got.alarm,
                              want.boiler_boost, got.boiler_boost,
                              want.shot_seconds_tenths, got.shot_seconds_tenths,
                              want.auto_shot, got.auto_shot, rsp_tdata[31:29]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(next_pass(req_tdata[0], req_tdata[1], req_tdata[2]));
         if (csr_we) apply_csr(csr_addr, csr_wdata);
      end
      pending_count = expected_q.size();
   end

endmodule

FILE: bench/tb_pump_pressure_profile_sequencer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pump pressure profile sequencer testbench
// Drives control passes through directed cases and random shot sequences over
// several register settings, with random idling on both channels; the checker
// beside the block predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_pump_pressure_profile_sequencer;
   import ppps_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 300_000;
   localparam int unsigned GAP_MAX         = 17;
   localparam int unsigned SETTLE_CYCLES   = 4;    // response is shown in the cycle after accept
   localparam int unsigned HOLD_OFF_CYCLES = 250;
   localparam int unsigned PHASE_BUDGET    = 60;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;   // [0] power_on, [1] brew_switch, [2] tick
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;         // [8:0] pump_duty, [9] brew_valve, [10] alarm,
                                          // [11] boiler_boost, [27:12] shot_seconds_tenths,
                                          // [28] auto_shot
   logic               csr_we     = 1'b0;
   logic [CSR_A_W-1:0] csr_addr   = '0;
   logic [CSR_W-1:0]   csr_wdata  = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned cycle_count   = 0;
   int unsigned phase_items   = 0;
   int unsigned hold_off_asked = 0;  // bumped by the sender, served by the receiver
   bit          tx_quiet = 1'b0;     // sender runs without gaps
   bit          rx_quiet = 1'b0;     // receiver runs without stalls

   // last profile written, needed to size a complete auto shot
   int unsigned prof_pi_stop = RST_PREINFUSE_END;
   int unsigned prof_soak    = RST_SOAK_END;

   initial forever #5 clock = ~clock;

   pump_pressure_profile_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ppps_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: a random stall before each response, a long hold-off when
   // the sender asks for one so the response register fills and req_tready drops.
   initial begin
      int unsigned stall;
      int unsigned hold_off_done;
      hold_off_done = 0;
      wait (reset == 1'b0);
      forever begin
         stall = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
         if (hold_off_asked != hold_off_done) begin
            hold_off_done++;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // one control pass as a request; returns just after the accepting edge
   task automatic send_pass(input bit pwr, input bit brew, input bit tick);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b00000, tick, brew, pwr};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      phase_items++;
   endtask

   // a run of passes with the switch held steady; ticks and power drops at random
   task automatic brew_run(input int unsigned n, input bit brew,
                           input int unsigned tick_pct, input int unsigned drop_pct);
      for (int unsigned i = 0; i < n; i++)
         send_pass($urandom_range(0, 99) >= drop_pct, brew, $urandom_range(0, 99) < tick_pct);
   endtask

   // stop offering, wait for every response, then let the block settle
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // every register, only ever between phases with the block idle
   task automatic set_profile(input int unsigned pi_duty, input int unsigned pi_stop,
                              input int unsigned soak, input int unsigned ramp,
                              input int unsigned decl, input int unsigned floor_duty,
                              input int unsigned warn);
      drain();
      write_csr(CSR_PREINFUSE_DUTY, CSR_W'(pi_duty));
      write_csr(CSR_PREINFUSE_END,  CSR_W'(pi_stop));
      write_csr(CSR_SOAK_END,       CSR_W'(soak));
      write_csr(CSR_RAMP_END,       CSR_W'(ramp));
      write_csr(CSR_HOLD_END,       CSR_W'(decl));
      write_csr(CSR_MIN_DUTY,       CSR_W'(floor_duty));
      write_csr(CSR_WARNING_START,  CSR_W'(warn));
      prof_pi_stop = pi_stop;
      prof_soak    = soak;
      phase_items  = 0;
   endtask

   // switch pressed briefly in preinfusion, then released until the auto shot ends
   task automatic auto_shot_full();
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      brew_run(2, 1'b0, 0, 0);
      brew_run(2, 1'b1, 100, 0);
      brew_run(AUTO_END_BASE + prof_soak - prof_pi_stop + 20, 1'b0, 100, 0);
   endtask

   // Random shots: mostly well-formed manual and auto shots with random ticks,
   // some pure noise and some shots broken by power drops.
   task automatic random_shots();
      int unsigned kind;
      while (phase_items < PHASE_BUDGET) begin
         kind     = $urandom_range(0, 9);
         tx_quiet = ($urandom_range(0, 4) == 0);
         rx_quiet = ($urandom_range(0, 4) == 0);
         brew_run($urandom_range(1, 4), 1'b0, 75, 0);
         if (kind <= 4) begin
            brew_run($urandom_range(5, 150), 1'b1, 75, 0);
         end else if (kind <= 7) begin
            brew_run($urandom_range(1, 4), 1'b1, 75, 0);
            brew_run($urandom_range(5, 120), 1'b0, 75, 0);
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 10))
               send_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end else begin
            brew_run($urandom_range(1, 30), 1'b1, 75, 10);
            brew_run($urandom_range(1, 40), 1'($urandom_range(0, 1)), 75, 15);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed, reset profile: every input combination, an auto shot cut by
      // power off, a manual shot cut by power off and resumed.
      for (int unsigned combo = 0; combo < 8; combo++)
         send_pass(combo[0], combo[1], combo[2]);
      brew_run(3, 1'b1, 100, 0);
      brew_run(4, 1'b0, 100, 0);
      send_pass(1'b0, 1'b0, 1'b1);
      send_pass(1'b1, 1'b0, 1'b0);
      brew_run(6, 1'b1, 100, 0);
      send_pass(1'b0, 1'b1, 1'b1);
      send_pass(1'b1, 1'b1, 1'b1);

      // Short profile: late hold, then the forgotten-switch alarm running to solid.
      // The receiver holds off meanwhile so the block stalls its input.
      set_profile(256, 4, 10, 40, 120, 30, 330);
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      brew_run(3, 1'b0, 0, 0);
      hold_off_asked++;
      brew_run(720, 1'b1, 95, 0);

      // all minimums
      set_profile(0, 0, 0, 0, 0, 0, 256);
      random_shots();

      // no ramp and a zero floor: the decline bottoms out at zero
      set_profile(200, 2, 4, 4, 300, 0, 300);
      random_shots();

      // all maximums
      set_profile(256, 255, 511, 511, 1023, 256, 1023);
      hold_off_asked++;
      random_shots();

      // two random profiles, preinfusion may run past the soak
      repeat (2) begin
         set_profile($urandom_range(0, 256), $urandom_range(0, 255), $urandom_range(0, 511),
                     $urandom_range(0, 511), $urandom_range(0, 1023), $urandom_range(0, 256),
                     $urandom_range(256, 1023));
         random_shots();
      end

      // reset values written back explicitly, with a complete auto shot
      set_profile(RST_PREINFUSE_DUTY, RST_PREINFUSE_END, RST_SOAK_END, RST_RAMP_END,
                  RST_HOLD_END, RST_MIN_DUTY, RST_WARNING_START);
      auto_shot_full();
      random_shots();

      drain();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
